// ----- hw/rtl/hfoc_pkg.sv -----
// hfoc_pkg: shared constants for the fan overrun controller
// mode codes, threshold limits and field widths; no dependencies
`timescale 1ns / 1ps

package hfoc_pkg;

  // decoded system mode
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_COOL = 2'd1;
  localparam logic [1:0] MODE_HEAT = 2'd2;
  localparam logic [1:0] MODE_ERR  = 2'd3;

  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned DELTA_W = 11;

  // stream payload widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  // fan-off threshold saturation limits, hundredths of a degree
  localparam logic signed [17:0] TGT_MIN = -18'sd8700;
  localparam logic signed [17:0] TGT_MAX = 18'sd27700;

  localparam logic [DELTA_W-1:0] DELTA_RESET = 11'd500;

  typedef logic signed [TEMP_W-1:0] temp_t;

endpackage

// ----- hw/rtl/hvac_fan_overrun_controller.sv -----
// hvac_fan_overrun_controller: fan overrun control with stream in/out ports
// depends on hfoc_pkg
`timescale 1ns / 1ps

// Keeps the air handler fan running after a cooling or heating call ends,
// until the temperature has drifted by overrun_delta (hundredths of a degree F)
// past the temperature at which the call ended. Each input transaction is
// either a temperature sample with the active-low cool/heat call lines
// (tuser = 0) or an override button press (tuser = 1); every input transaction
// produces exactly one output transaction with fan state, decoded mode, fan-off
// target and a display refresh flag. An input register feeds a single pass of
// mode decode, saturating add/subtract and compare, and the result lands in
// the output register together with the controller state. The block takes
// one transaction per clock as long as the output side keeps tready high;
// throughput is set by the state update. A stall on the output side backs
// up through both registers. overrun_delta is written through cfg_wr_en_i /
// cfg_wr_data_i and resets to 500; the user must write it only while no
// transaction is in flight, which the block itself does not enforce.

module hvac_fan_overrun_controller (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_wr_en_i,
  input  logic [hfoc_pkg::DELTA_W-1:0]       cfg_wr_data_i,   // overrun_delta
  // input stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [15:0] temperature, [16] cool_line, [17] heat_line, [23:18] zero
  input  logic [hfoc_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // [0] command: 0 sample, 1 override
  input  logic                               s_axis_tuser_i,
  // output stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [0] fan_on, [2:1] system_mode, [18:3] target_temp, [19] display_changed,
  // [23:20] zero
  output logic [hfoc_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);

  import hfoc_pkg::*;

  // configuration register
  logic [DELTA_W-1:0] delta_q;

  // input register
  logic       in_vld_q;
  logic       cmd_q;
  temp_t      temp_q;
  logic       cool_q, heat_q;

  // output register
  logic       out_vld_q;
  logic       o_fan_q;
  logic [1:0] o_mode_q;
  temp_t      o_tgt_q;
  logic       o_chg_q;

  // controller state
  logic [1:0] last_mode_q, last_mode_d;
  logic       fan_q, fan_d;
  temp_t      off_temp_q, off_temp_d;
  temp_t      stop_q, stop_d;
  logic       pend_q, pend_d;

  logic       out_adv;
  logic       proc_fire;
  logic       changed;
  logic [1:0] mode;
  logic signed [17:0] sum_up, sum_dn;
  temp_t      tgt_up, tgt_dn;

  // the output register frees up when empty or being taken
  assign out_adv         = !out_vld_q || m_axis_tready_i;
  assign proc_fire       = in_vld_q && out_adv;
  assign s_axis_tready_o = !in_vld_q || out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= DELTA_RESET;
    end else if (cfg_wr_en_i) begin
      delta_q <= cfg_wr_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      cmd_q  <= s_axis_tuser_i;
      temp_q <= s_axis_tdata_i[TEMP_W-1:0];
      cool_q <= s_axis_tdata_i[TEMP_W];
      heat_q <= s_axis_tdata_i[TEMP_W+1];
    end
  end

  // mode decode, lines are active low
  always_comb begin
    if (!cool_q && !heat_q) begin
      mode = MODE_ERR;
    end else if (!cool_q) begin
      mode = MODE_COOL;
    end else if (!heat_q) begin
      mode = MODE_HEAT;
    end else begin
      mode = MODE_OFF;
    end
  end

  // saturating target after cooling (up) and heating (down)
  assign sum_up = {{2{temp_q[TEMP_W-1]}}, temp_q} + signed'({7'd0, delta_q});
  assign sum_dn = {{2{temp_q[TEMP_W-1]}}, temp_q} - signed'({7'd0, delta_q});

  // both sums clamp at either limit, the sample itself may lie outside them
  always_comb begin
    if (sum_up > TGT_MAX) begin
      tgt_up = TGT_MAX[TEMP_W-1:0];
    end else if (sum_up < TGT_MIN) begin
      tgt_up = TGT_MIN[TEMP_W-1:0];
    end else begin
      tgt_up = sum_up[TEMP_W-1:0];
    end
    if (sum_dn < TGT_MIN) begin
      tgt_dn = TGT_MIN[TEMP_W-1:0];
    end else if (sum_dn > TGT_MAX) begin
      tgt_dn = TGT_MAX[TEMP_W-1:0];
    end else begin
      tgt_dn = sum_dn[TEMP_W-1:0];
    end
  end

  // next controller state for the transaction in the input register
  always_comb begin
    last_mode_d = last_mode_q;
    fan_d       = fan_q;
    off_temp_d  = off_temp_q;
    stop_d      = stop_q;
    pend_d      = pend_q;
    changed     = 1'b0;

    if (cmd_q) begin
      // override press: stop now, clear the target on the next sample
      changed = fan_q;
      fan_d   = 1'b0;
      pend_d  = 1'b1;
    end else begin
      if (mode != last_mode_q) begin
        if (mode == MODE_COOL || mode == MODE_HEAT) begin
          fan_d  = 1'b1;
          stop_d = '0;
        end else if (fan_q) begin
          // call ended with the fan running: arm the overrun target
          off_temp_d = temp_q;
          if (last_mode_q == MODE_COOL) begin
            stop_d = tgt_up;
          end else if (last_mode_q == MODE_HEAT) begin
            stop_d = tgt_dn;
          end
        end
        last_mode_d = mode;
        changed     = 1'b1;
      end

      if (pend_q) begin
        pend_d  = 1'b0;
        stop_d  = '0;
        changed = 1'b1;
      end else if (stop_d > off_temp_d && temp_q >= stop_d) begin
        // drifted up past the target after cooling
        fan_d   = 1'b0;
        changed = 1'b1;
      end else if (stop_d < off_temp_d && temp_q <= stop_d) begin
        // drifted down past the target after heating
        fan_d   = 1'b0;
        changed = 1'b1;
      end
    end
  end

  // state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_mode_q <= MODE_OFF;
      fan_q       <= 1'b0;
      off_temp_q  <= '0;
      stop_q      <= '0;
      pend_q      <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (out_adv) begin
        out_vld_q <= in_vld_q;
      end
      if (proc_fire) begin
        last_mode_q <= last_mode_d;
        fan_q       <= fan_d;
        off_temp_q  <= off_temp_d;
        stop_q      <= stop_d;
        pend_q      <= pend_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      o_fan_q  <= fan_d;
      o_mode_q <= last_mode_d;
      o_tgt_q  <= stop_d;
      o_chg_q  <= changed;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'd0, o_chg_q, o_tgt_q, o_mode_q, o_fan_q};

`ifndef SYNTHESIS
  // an override always leaves the fan stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && cmd_q) |=> !fan_q)
    else $error("fan running after override");

  // a pending override can only sit behind override presses, fan stays off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !fan_q)
    else $error("override pending with fan running");

  // target is either cleared or a saturated value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (TEMP_W'(TGT_MIN) <= stop_q) && (stop_q <= TEMP_W'(TGT_MAX)))
    else $error("stop threshold out of range");

  // controller state does not move while a result is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready_i) |=>
      ($stable(fan_q) && $stable(stop_q) && $stable(last_mode_q) && $stable(pend_q)))
    else $error("state changed during output stall");
`endif

endmodule
